// ===== hdl/psae_pkg.sv =====
`timescale 1ns / 1ps

package psae_pkg;

    localparam int MAX_PACKETS = 64;

    localparam int CFG_W      = 16;
    localparam int PAYLOAD_W  = 20;
    localparam int TOTAL_W    = PAYLOAD_W + 1;
    localparam int DIV_NUM_W  = PAYLOAD_W + 2;
    localparam int DIV_DEN_W  = CFG_W;
    localparam int DIV_CNT_W  = $clog2(DIV_NUM_W);
    localparam int COUNT_W    = $clog2(MAX_PACKETS) + 1;
    localparam int LEFT_W     = COUNT_W + 1;

    typedef enum logic [1:0] {
        CFG_MAX_PAYLOAD  = 2'd0,
        CFG_SINGLE_RED   = 2'd1,
        CFG_FIRST_RED    = 2'd2,
        CFG_LAST_RED     = 2'd3
    } t_cfg_index;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NO_ROOM  = 2'd1,
        ST_TOO_MANY = 2'd2
    } t_status;

    localparam logic [CFG_W-1:0] MAX_PAYLOAD_RESET = 16'd1200;

endpackage

// ===== hdl/payload_split_about_equal.sv =====
`timescale 1ns / 1ps

// payload_split_about_equal
// Splits a payload size into packet sizes of about equal length.
// Configuration: a write transfer on i_cfg_valid / o_cfg_ready with a register
// index and 16-bit data; o_cfg_ready is always high. Write only while busy is low.
// Input: a transfer happens when start is high and busy is low, carrying
// i_payload_bytes. busy stays high until the last result is driven.
// Output: each result is shown for one cycle with o_valid high; o_is_last marks
// the final result of an item, o_status flags errors (one result, zero bytes).
// The receiver cannot stall; results are never held back.
// Sequence: a payload that fits one packet, or reductions that leave no room,
// gives its result straight from the check, without the divider. A split runs the
// shared 22-step divider twice (packet count, then base size and remainder), then
// gives one size per cycle. Too few bytes for the packet count or too many packets
// give the error result after the first division.
// An empty payload gives no result if it reaches the second division.
// A new item is taken only once busy is low, after the last result of the item before.
// Reset: synchronous, active low; registers return to their defaults
// (max payload 1200, reductions 0) and the block goes idle.

module payload_split_about_equal (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [psae_pkg::PAYLOAD_W-1:0]    i_payload_bytes,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [1:0]                        i_cfg_index,
    input  logic [psae_pkg::CFG_W-1:0]        i_cfg_data,
    output logic                              o_valid,
    output logic [psae_pkg::PAYLOAD_W-1:0]    o_packet_bytes,
    output logic                              o_is_last,
    output logic [1:0]                        o_status
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_DIV1,
        S_EVAL,
        S_DIV2,
        S_EMIT
    } t_state;

    t_state r_state;

    logic [psae_pkg::CFG_W-1:0]      r_max_payload;
    logic [psae_pkg::CFG_W-1:0]      r_single_red;
    logic [psae_pkg::CFG_W-1:0]      r_first_red;
    logic [psae_pkg::CFG_W-1:0]      r_last_red;

    logic [psae_pkg::PAYLOAD_W-1:0]  r_payload;
    logic [psae_pkg::TOTAL_W-1:0]    r_total;
    logic [psae_pkg::DIV_NUM_W-1:0]  r_n;
    logic [psae_pkg::PAYLOAD_W-1:0]  r_bytes_rem;
    logic [psae_pkg::LEFT_W-1:0]     r_left;
    logic [psae_pkg::TOTAL_W-1:0]    r_base;
    logic [psae_pkg::COUNT_W-1:0]    r_larger;
    logic                            r_first;
    logic [psae_pkg::COUNT_W-1:0]    r_count;

    logic                            r_valid;
    logic [psae_pkg::PAYLOAD_W-1:0]  r_packet_bytes;
    logic                            r_is_last;
    psae_pkg::t_status               r_status;

    logic                            div_start;
    logic [psae_pkg::DIV_NUM_W-1:0]  div_num;
    logic [psae_pkg::DIV_DEN_W-1:0]  div_den;
    logic                            div_done;
    logic [psae_pkg::DIV_NUM_W-1:0]  div_quo;
    logic [psae_pkg::DIV_DEN_W-1:0]  div_rem;

    logic                            fits_one;
    logic                            no_room;
    logic [psae_pkg::TOTAL_W-1:0]    total;
    logic [psae_pkg::DIV_NUM_W-1:0]  n_count;

    logic                            inc;
    logic [psae_pkg::TOTAL_W-1:0]    base_n;
    logic [psae_pkg::TOTAL_W-1:0]    fr_plus1;
    logic [psae_pkg::TOTAL_W-1:0]    cur_a;
    logic [psae_pkg::PAYLOAD_W-1:0]  cur_b;
    logic [psae_pkg::PAYLOAD_W-1:0]  cur;
    logic [psae_pkg::PAYLOAD_W-1:0]  rem_n;
    logic                            emit_last;

    psae_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quo   (div_quo),
        .o_rem   (div_rem)
    );

    assign o_cfg_ready = 1'b1;
    assign busy        = (r_state != S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_payload <= psae_pkg::MAX_PAYLOAD_RESET;
            r_single_red  <= '0;
            r_first_red   <= '0;
            r_last_red    <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (psae_pkg::t_cfg_index'(i_cfg_index))
                psae_pkg::CFG_MAX_PAYLOAD: r_max_payload <= i_cfg_data;
                psae_pkg::CFG_SINGLE_RED:  r_single_red  <= i_cfg_data;
                psae_pkg::CFG_FIRST_RED:   r_first_red   <= i_cfg_data;
                psae_pkg::CFG_LAST_RED:    r_last_red    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        fits_one = {5'd0, r_max_payload} >=
                   ({1'b0, r_payload} + {5'd0, r_single_red});
        no_room  = (r_first_red >= r_max_payload) || (r_last_red >= r_max_payload) ||
                   (r_max_payload == '0);
        total    = {1'b0, r_payload} + {5'd0, r_first_red} + {5'd0, r_last_red};
        n_count  = (div_quo == psae_pkg::DIV_NUM_W'(1)) ?
                   psae_pkg::DIV_NUM_W'(2) : div_quo;
    end

    // divider operands: packet count first, then base size
    always_comb begin
        div_start = 1'b0;
        div_num   = {1'b0, r_total};
        div_den   = psae_pkg::DIV_DEN_W'(r_n);
        if (r_state == S_CHECK) begin
            div_start = !fits_one && !no_room;
            div_num   = {1'b0, total} + {6'd0, r_max_payload} - psae_pkg::DIV_NUM_W'(1);
            div_den   = r_max_payload;
        end else if (r_state == S_EVAL) begin
            div_start = !({2'd0, r_payload} < r_n) &&
                        !(r_n > psae_pkg::DIV_NUM_W'(psae_pkg::MAX_PACKETS));
        end
    end

    // size of the next packet
    always_comb begin
        inc      = (r_left == {1'b0, r_larger});
        base_n   = r_base + psae_pkg::TOTAL_W'(inc);
        fr_plus1 = {5'd0, r_first_red} + psae_pkg::TOTAL_W'(1);
        if (r_first) begin
            cur_a = (base_n > fr_plus1) ? base_n - {5'd0, r_first_red} :
                    psae_pkg::TOTAL_W'(1);
        end else begin
            cur_a = base_n;
        end
        cur_b = (cur_a > {1'b0, r_bytes_rem}) ? r_bytes_rem :
                cur_a[psae_pkg::PAYLOAD_W-1:0];
        if (r_left == psae_pkg::LEFT_W'(2) && cur_b == r_bytes_rem) begin
            cur = cur_b - 1'b1;
        end else begin
            cur = cur_b;
        end
        rem_n     = r_bytes_rem - cur;
        emit_last = (rem_n == '0) ||
                    (r_count == psae_pkg::COUNT_W'(psae_pkg::MAX_PACKETS - 1));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_payload <= i_payload_bytes;
                        r_state   <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    r_total <= total;
                    if (fits_one) begin
                        r_valid        <= 1'b1;
                        r_packet_bytes <= r_payload;
                        r_is_last      <= 1'b1;
                        r_status       <= psae_pkg::ST_OK;
                        r_state        <= S_IDLE;
                    end else if (no_room) begin
                        r_valid        <= 1'b1;
                        r_packet_bytes <= '0;
                        r_is_last      <= 1'b1;
                        r_status       <= psae_pkg::ST_NO_ROOM;
                        r_state        <= S_IDLE;
                    end else begin
                        r_state <= S_DIV1;
                    end
                end
                S_DIV1: begin
                    if (div_done) begin
                        r_n     <= n_count;
                        r_state <= S_EVAL;
                    end
                end
                S_EVAL: begin
                    if ({2'd0, r_payload} < r_n) begin
                        r_valid        <= 1'b1;
                        r_packet_bytes <= '0;
                        r_is_last      <= 1'b1;
                        r_status       <= psae_pkg::ST_NO_ROOM;
                        r_state        <= S_IDLE;
                    end else if (r_n > psae_pkg::DIV_NUM_W'(psae_pkg::MAX_PACKETS)) begin
                        r_valid        <= 1'b1;
                        r_packet_bytes <= '0;
                        r_is_last      <= 1'b1;
                        r_status       <= psae_pkg::ST_TOO_MANY;
                        r_state        <= S_IDLE;
                    end else begin
                        r_state <= S_DIV2;
                    end
                end
                S_DIV2: begin
                    if (div_done) begin
                        r_base      <= div_quo[psae_pkg::TOTAL_W-1:0];
                        r_larger    <= div_rem[psae_pkg::COUNT_W-1:0];
                        r_left      <= psae_pkg::LEFT_W'(r_n);
                        r_bytes_rem <= r_payload;
                        r_first     <= 1'b1;
                        r_count     <= '0;
                        // empty payload has no packet to emit
                        if (r_payload == '0) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_state <= S_EMIT;
                        end
                    end
                end
                S_EMIT: begin
                    r_base         <= base_n;
                    r_bytes_rem    <= rem_n;
                    r_left         <= r_left - 1'b1;
                    r_first        <= 1'b0;
                    r_count        <= r_count + 1'b1;
                    r_valid        <= 1'b1;
                    r_packet_bytes <= cur;
                    r_is_last      <= emit_last;
                    r_status       <= psae_pkg::ST_OK;
                    if (emit_last) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid        = r_valid;
    assign o_packet_bytes = r_packet_bytes;
    assign o_is_last      = r_is_last;
    assign o_status       = r_status;

endmodule

// ===== hdl/psae_div.sv =====
`timescale 1ns / 1ps

module psae_div (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic [psae_pkg::DIV_NUM_W-1:0]    i_num,
    input  logic [psae_pkg::DIV_DEN_W-1:0]    i_den,
    output logic                              o_done,
    output logic [psae_pkg::DIV_NUM_W-1:0]    o_quo,
    output logic [psae_pkg::DIV_DEN_W-1:0]    o_rem
);

    logic                              r_run;
    logic                              r_done;
    logic [psae_pkg::DIV_CNT_W-1:0]    r_cnt;
    logic [psae_pkg::DIV_NUM_W-1:0]    r_num;
    logic [psae_pkg::DIV_DEN_W-1:0]    r_rem;
    logic [psae_pkg::DIV_DEN_W-1:0]    r_den;

    logic [psae_pkg::DIV_DEN_W:0]      trial;
    logic                              fits;
    logic [psae_pkg::DIV_DEN_W-1:0]    n_rem;

    // one quotient bit per cycle, restoring
    always_comb begin
        trial = {r_rem, r_num[psae_pkg::DIV_NUM_W-1]};
        fits  = trial >= {1'b0, r_den};
        if (fits) begin
            n_rem = psae_pkg::DIV_DEN_W'(trial - {1'b0, r_den});
        end else begin
            n_rem = trial[psae_pkg::DIV_DEN_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_run <= 1'b1;
                r_cnt <= '0;
                r_num <= i_num;
                r_den <= i_den;
                r_rem <= '0;
            end else if (r_run) begin
                r_rem <= n_rem;
                r_num <= {r_num[psae_pkg::DIV_NUM_W-2:0], fits};
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == psae_pkg::DIV_CNT_W'(psae_pkg::DIV_NUM_W - 1)) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_num;
    assign o_rem  = r_rem;

endmodule

// ===== tb/sv/packet_size_checker.sv =====
`timescale 1ns / 1ps

module packet_size_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic                           i_busy,
    input  logic [psae_pkg::PAYLOAD_W-1:0] i_payload_bytes,
    input  logic                           i_cfg_valid,
    input  logic                           i_cfg_ready,
    input  logic [1:0]                     i_cfg_index,
    input  logic [psae_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic                           i_valid,
    input  logic [psae_pkg::PAYLOAD_W-1:0] i_packet_bytes,
    input  logic                           i_is_last,
    input  logic [1:0]                     i_status,
    output int                             o_fail_count,
    output int                             o_pending,
    output int                             o_result_count
);

    typedef struct packed {
        logic [psae_pkg::PAYLOAD_W-1:0] bytes;
        logic                           last;
        psae_pkg::t_status              status;
    } t_packet;

    t_packet packet_q[$];

    logic [psae_pkg::CFG_W-1:0] max_payload;
    logic [psae_pkg::CFG_W-1:0] single_red;
    logic [psae_pkg::CFG_W-1:0] first_red;
    logic [psae_pkg::CFG_W-1:0] last_red;

    int bytes_left;
    int pkts_left;
    int base_size;
    int larger_count;
    bit first_pending;

    int fails = 0;
    int results = 0;

    function automatic void push_packet(input logic [psae_pkg::PAYLOAD_W-1:0] bytes,
                                        input logic last,
                                        input psae_pkg::t_status status);
        t_packet pkt;
        pkt.bytes  = bytes;
        pkt.last   = last;
        pkt.status = status;
        packet_q   = {packet_q, pkt};
    endfunction

    function automatic void predict_packet_sizes(input logic [psae_pkg::PAYLOAD_W-1:0] payload);
        int p;
        int maxp;
        int fr;
        int lr;
        int total;
        int n;
        int cur;
        int count;
        logic [psae_pkg::PAYLOAD_W-1:0] sizes [psae_pkg::MAX_PACKETS];
        p     = int'(payload);
        maxp  = int'(max_payload);
        fr    = int'(first_red);
        lr    = int'(last_red);
        count = 0;
        if (maxp >= p + int'(single_red)) begin
            push_packet(payload, 1'b1, psae_pkg::ST_OK);
            return;
        end
        if (maxp - fr < 1 || maxp - lr < 1 || maxp <= 0) begin
            push_packet('0, 1'b1, psae_pkg::ST_NO_ROOM);
            return;
        end
        total = p + fr + lr;
        n = (total + maxp - 1) / maxp;
        if (n == 1) n = 2;
        if (p < n) begin
            push_packet('0, 1'b1, psae_pkg::ST_NO_ROOM);
            return;
        end
        if (n > psae_pkg::MAX_PACKETS) begin
            push_packet('0, 1'b1, psae_pkg::ST_TOO_MANY);
            return;
        end
        pkts_left     = n;
        base_size     = total / n;
        larger_count  = total % n;
        bytes_left    = p;
        first_pending = 1'b1;
        while (bytes_left > 0 && count < psae_pkg::MAX_PACKETS) begin
            if (pkts_left == larger_count) base_size++;
            cur = base_size;
            if (first_pending) cur = (cur > fr + 1) ? cur - fr : 1;
            if (cur > bytes_left) cur = bytes_left;
            if (pkts_left == 2 && cur == bytes_left) cur--;
            bytes_left    -= cur;
            pkts_left--;
            first_pending = 1'b0;
            sizes[count]  = psae_pkg::PAYLOAD_W'(cur);
            count++;
        end
        for (int k = 0; k < count; k++) begin
            push_packet(sizes[k], k == count - 1, psae_pkg::ST_OK);
        end
    endfunction

    always @(posedge i_clk) begin
        t_packet want;
        if (!i_rst_n) begin
            packet_q.delete();
            max_payload   = psae_pkg::MAX_PAYLOAD_RESET;
            single_red    = '0;
            first_red     = '0;
            last_red      = '0;
            bytes_left    = 0;
            pkts_left     = 0;
            base_size     = 0;
            larger_count  = 0;
            first_pending = 1'b1;
        end else begin
            if (i_valid) begin
                results++;
                if (packet_q.size() == 0) begin
                    $error("packet result with nothing pending: packet_bytes %0d status %0d",
                           i_packet_bytes, i_status);
                    fails++;
                end else begin
                    want = packet_q.pop_front();
                    if (i_packet_bytes !== want.bytes) begin
                        $error("packet_bytes: expected %0d, actual %0d", want.bytes,
                               i_packet_bytes);
                        fails++;
                    end
                    if (i_is_last !== want.last) begin
                        $error("is_last: expected %0d, actual %0d", want.last, i_is_last);
                        fails++;
                    end
                    if (i_status !== want.status) begin
                        $error("status: expected %0d, actual %0d", want.status, i_status);
                        fails++;
                    end
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                case (psae_pkg::t_cfg_index'(i_cfg_index))
                    psae_pkg::CFG_MAX_PAYLOAD: max_payload = i_cfg_data;
                    psae_pkg::CFG_SINGLE_RED:  single_red  = i_cfg_data;
                    psae_pkg::CFG_FIRST_RED:   first_red   = i_cfg_data;
                    psae_pkg::CFG_LAST_RED:    last_red    = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_start && !i_busy) predict_packet_sizes(i_payload_bytes);
        end
        o_fail_count   <= fails;
        o_pending      <= packet_q.size();
        o_result_count <= results;
    end

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_PER_PHASE = 25;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n = 1'b0;
    logic                           start = 1'b0;
    logic                           busy;
    logic [psae_pkg::PAYLOAD_W-1:0] i_payload_bytes = '0;
    logic                           i_cfg_valid = 1'b0;
    logic                           o_cfg_ready;
    logic [1:0]                     i_cfg_index = psae_pkg::CFG_MAX_PAYLOAD;
    logic [psae_pkg::CFG_W-1:0]     i_cfg_data = '0;
    logic                           o_valid;
    logic [psae_pkg::PAYLOAD_W-1:0] o_packet_bytes;
    logic                           o_is_last;
    logic [1:0]                     o_status;

    int fail_count;
    int pending;
    int result_count;
    int idle_cycles = 0;
    int item_count = 0;
    int setting_count = 0;

    int cur_maxp = int'(psae_pkg::MAX_PAYLOAD_RESET);
    int cur_sr = 0;
    int cur_fr = 0;
    int cur_lr = 0;

    int unsigned directed_q[$];

    always #1 i_clk = ~i_clk;

    payload_split_about_equal u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_payload_bytes (i_payload_bytes),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .o_valid         (o_valid),
        .o_packet_bytes  (o_packet_bytes),
        .o_is_last       (o_is_last),
        .o_status        (o_status)
    );

    packet_size_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (start),
        .i_busy          (busy),
        .i_payload_bytes (i_payload_bytes),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_valid         (o_valid),
        .i_packet_bytes  (o_packet_bytes),
        .i_is_last       (o_is_last),
        .i_status        (o_status),
        .o_fail_count    (fail_count),
        .o_pending       (pending),
        .o_result_count  (result_count)
    );

    // any transfer resets the watchdog
    always @(posedge i_clk) begin
        if ((start && !busy) || (i_cfg_valid && o_cfg_ready) || o_valid) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
    end

    initial begin
        while (idle_cycles < WATCHDOG_LIMIT) @(posedge i_clk);
        $display("simulation failed");
        $finish;
    end

    function automatic int pick_gap();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 55) return 0;
        if (sel < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // mostly payloads near a chosen packet count, some across the whole range, some small
    function automatic logic [psae_pkg::PAYLOAD_W-1:0] pick_payload();
        longint lo;
        longint hi;
        longint n;
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 70) begin
            n  = $urandom_range(1, psae_pkg::MAX_PACKETS + 2);
            hi = n * cur_maxp - cur_fr - cur_lr;
            lo = hi - cur_maxp;
        end else if (sel < 85) begin
            return psae_pkg::PAYLOAD_W'($urandom_range(0, (1 << psae_pkg::PAYLOAD_W) - 1));
        end else begin
            lo = 0;
            hi = 2 * cur_maxp + 4;
        end
        if (lo < 0) lo = 0;
        if (hi < lo) hi = lo;
        if (hi > (1 << psae_pkg::PAYLOAD_W) - 1) hi = (1 << psae_pkg::PAYLOAD_W) - 1;
        if (lo > hi) lo = hi;
        return psae_pkg::PAYLOAD_W'(lo + $urandom_range(0, int'(hi - lo)));
    endfunction

    task automatic send_payload(input logic [psae_pkg::PAYLOAD_W-1:0] payload, input int gap);
        start           <= 1'b1;
        i_payload_bytes <= payload;
        do @(posedge i_clk); while (busy);
        item_count++;
        if (gap > 0) begin
            start           <= 1'b0;
            i_payload_bytes <= psae_pkg::PAYLOAD_W'($urandom);
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic send_directed();
        while (directed_q.size() > 0) begin
            send_payload(psae_pkg::PAYLOAD_W'(directed_q.pop_front()), pick_gap());
        end
    endtask

    task automatic send_random(input int n);
        bit no_gaps;
        no_gaps = ($urandom_range(0, 2) == 0);
        repeat (n) send_payload(pick_payload(), no_gaps ? 0 : pick_gap());
    endtask

    task automatic wait_idle();
        start <= 1'b0;
        do @(posedge i_clk); while (pending != 0 || busy);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input psae_pkg::t_cfg_index idx, input int value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= psae_pkg::CFG_W'(value);
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    task automatic apply_config(input int maxp, input int sr, input int fr, input int lr);
        write_reg(psae_pkg::CFG_MAX_PAYLOAD, maxp);
        write_reg(psae_pkg::CFG_SINGLE_RED, sr);
        write_reg(psae_pkg::CFG_FIRST_RED, fr);
        write_reg(psae_pkg::CFG_LAST_RED, lr);
        i_cfg_valid <= 1'b0;
        cur_maxp = maxp;
        cur_sr   = sr;
        cur_fr   = fr;
        cur_lr   = lr;
        setting_count++;
    endtask

    task automatic random_config();
        int maxp;
        int sel;
        sel = $urandom_range(0, 3);
        if (sel < 2) maxp = $urandom_range(2, 1500);
        else if (sel == 2) maxp = $urandom_range(1, 65535);
        else maxp = $urandom_range(1, 40);
        apply_config(maxp,
                     ($urandom_range(0, 9) < 7) ? $urandom_range(0, maxp)
                                                : $urandom_range(0, 65535),
                     ($urandom_range(0, 9) < 8) ? $urandom_range(0, maxp / 3)
                                                : $urandom_range(0, 65535),
                     ($urandom_range(0, 9) < 8) ? $urandom_range(0, maxp / 3)
                                                : $urandom_range(0, 65535));
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // values after reset
        setting_count = 1;
        directed_q = {0, 1, 1200, 1201, 2401, 76800, 76801, (1 << psae_pkg::PAYLOAD_W) - 1};
        send_directed();
        send_random(RANDOM_PER_PHASE);
        wait_idle();

        // tiny packets, first packet shrunk to one byte, empty payload with no room
        apply_config(2, 5, 1, 1);
        directed_q = {0, 1, 2};
        send_directed();
        send_random(RANDOM_PER_PHASE);
        wait_idle();

        // one byte kept back for the last packet
        apply_config(10, 100, 0, 9);
        directed_q = {2};
        send_directed();
        send_random(RANDOM_PER_PHASE);
        wait_idle();

        apply_config(10, 0, 10, 0);
        directed_q = {11};
        send_directed();
        send_random(RANDOM_PER_PHASE / 2);
        wait_idle();

        apply_config(10, 0, 0, 10);
        directed_q = {11};
        send_directed();
        send_random(RANDOM_PER_PHASE / 2);
        wait_idle();

        apply_config(65535, 65535, 65534, 65534);
        directed_q = {0, 1, 2, (1 << psae_pkg::PAYLOAD_W) - 1};
        send_directed();
        send_random(RANDOM_PER_PHASE);
        wait_idle();

        apply_config(0, 0, 0, 0);
        directed_q = {0, 1};
        send_directed();
        send_random(RANDOM_PER_PHASE / 2);
        wait_idle();

        // one byte per packet up to the packet limit
        apply_config(1, 0, 0, 0);
        directed_q = {64, 65};
        send_directed();
        send_random(RANDOM_PER_PHASE);
        wait_idle();

        for (int k = 0; k < 6; k++) begin
            random_config();
            send_random(RANDOM_PER_PHASE);
            wait_idle();
        end

        repeat (16) @(posedge i_clk);
        $display("covered %0d payload transfers under %0d register settings", item_count,
                 setting_count);
        $display("checked %0d packet results, %0d mismatches", result_count, fail_count);
        if (fail_count == 0 && pending == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
